/* src/rnnsc_pkg.sv */
// ----------------------------------------------------------------------------
// rnnsc_pkg: shared constants, types and tables for the RNN classifier
// Q4.12 formats, region codes, tanh and 2^-x tables.
// ----------------------------------------------------------------------------
`default_nettype none
package rnnsc_pkg;
   localparam int HIDDEN_SIZE_DEF = 32;
   localparam int EMBED_SIZE_DEF  = 32;
   localparam int OUTPUT_SIZE_DEF = 2;
   localparam int VOCAB_SIZE_DEF  = 1024;

   localparam logic [2:0] REG_EMBED = 3'd0;
   localparam logic [2:0] REG_WX    = 3'd1;
   localparam logic [2:0] REG_WH    = 3'd2;
   localparam logic [2:0] REG_BH    = 3'd3;
   localparam logic [2:0] REG_WY    = 3'd4;
   localparam logic [2:0] REG_BY    = 3'd5;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_TOKEN = 1'b1;

   typedef logic signed [15:0] q412_type;
   typedef logic signed [47:0] acc_type;

   function automatic logic [12:0] tanh_tab(input logic [5:0] i);
      logic [12:0] r;
      case (i)
         6'd0: r = 13'd0;     6'd1: r = 13'd1003;  6'd2: r = 13'd1893;
         6'd3: r = 13'd2602;  6'd4: r = 13'd3119;  6'd5: r = 13'd3475;
         6'd6: r = 13'd3707;  6'd7: r = 13'd3856;  6'd8: r = 13'd3949;
         6'd9: r = 13'd4006;  6'd10: r = 13'd4041; 6'd11: r = 13'd4062;
         6'd12: r = 13'd4076; 6'd13: r = 13'd4084; 6'd14: r = 13'd4089;
         6'd15: r = 13'd4091; 6'd16: r = 13'd4093; 6'd17: r = 13'd4094;
         6'd18: r = 13'd4095; 6'd19: r = 13'd4095;
         default: r = 13'd4096;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] pow2_tab(input logic [4:0] i);
      logic [16:0] r;
      case (i)
         5'd0: r = 17'd65536;  5'd1: r = 17'd62757;  5'd2: r = 17'd60097;
         5'd3: r = 17'd57549;  5'd4: r = 17'd55109;  5'd5: r = 17'd52773;
         5'd6: r = 17'd50535;  5'd7: r = 17'd48393;  5'd8: r = 17'd46341;
         5'd9: r = 17'd44376;  5'd10: r = 17'd42495; 5'd11: r = 17'd40693;
         5'd12: r = 17'd38968; 5'd13: r = 17'd37316; 5'd14: r = 17'd35734;
         5'd15: r = 17'd34219;
         default: r = 17'd32768;
      endcase
      return r;
   endfunction

   // round Q24.24 sum to Q4.12 with saturation
   function automatic q412_type to_q412(input acc_type a);
      acc_type v;
      acc_type q;
      v = a + acc_type'(2048);
      q = v >>> 12;
      if (q > acc_type'(32767)) return q412_type'(16'sh7fff);
      if (q < -acc_type'(32768)) return q412_type'(-17'sd32768);
      return q[15:0];
   endfunction

   // tanh by linear interpolation over a 33-entry table
   function automatic q412_type tanh_q(input q412_type x);
      logic [16:0] mag;
      logic [5:0]  idx;
      logic [9:0]  frac;
      logic [12:0] a, b;
      logic [23:0] prod;
      logic [12:0] r;
      mag  = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
      idx  = mag[15:10];
      frac = mag[9:0];
      a    = tanh_tab(idx);
      b    = tanh_tab(6'(idx + 6'd1));
      prod = 24'(b - a) * 24'(frac) + 24'd512;
      r    = (idx >= 6'd32) ? 13'd4096 : 13'(a + 13'(prod >> 10));
      return x[15] ? q412_type'(-$signed({3'b000, r})) : q412_type'({3'b000, r});
   endfunction
endpackage
`default_nettype wire

/* src/rnnsc_divider.sv */
// ----------------------------------------------------------------------------
// rnnsc_divider: restoring divider, one quotient bit per cycle
// Computes floor(num / den) for the softmax normalization.
// ----------------------------------------------------------------------------
`default_nettype none
module rnnsc_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [40:0] num,
   input  wire logic [20:0] den,
   output logic             done,
   output logic [40:0]      quo
);
   logic [40:0] q_ff, q_in;
   logic [21:0] r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [20:0] den_ff, den_in;
   logic [21:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; busy_in = busy_ff; den_in = den_ff;
      done = 1'b0;
      trial = {r_ff[20:0], q_ff[40]};
      if (start) begin
         q_in = num; r_in = '0; cnt_in = 6'd41; busy_in = 1'b1; den_in = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            r_in = trial - {1'b0, den_ff};
            q_in = {q_ff[39:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[39:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end else begin
         done = 1'b0;
      end
      if (busy_ff && cnt_ff == 6'd1) begin
         done = 1'b1;
      end
   end
   assign quo = q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      den_ff <= den_in;
   end
endmodule
`default_nettype wire

/* src/rnn_sequence_classifier_top.sv */
// ----------------------------------------------------------------------------
// rnn_sequence_classifier_top: Elman RNN sequence classifier, Q4.12
// Parameter stores in synchronous RAMs, one MAC, tanh/exp tables, divider.
// ----------------------------------------------------------------------------
// channel | direction | ports
// req     | in        | req_valid/req_ready, func..end_of_sequence
// rsp     | out       | rsp_valid/rsp_ready, class_index..last_result
//
// A token's run time is set by the one MAC reading one weight per cycle;
// the last token adds the logits and a divider pass for each class.
// Reset clears control and the hidden vector valid state. A stalled result
// holds the sequencer; no new transaction is taken until all results leave.
`default_nettype none
module rnn_sequence_classifier_top #(
   parameter int HIDDEN_SIZE = rnnsc_pkg::HIDDEN_SIZE_DEF,
   parameter int EMBED_SIZE  = rnnsc_pkg::EMBED_SIZE_DEF,
   parameter int OUTPUT_SIZE = rnnsc_pkg::OUTPUT_SIZE_DEF,
   parameter int VOCAB_SIZE  = rnnsc_pkg::VOCAB_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [2:0]  req_region,
   input  wire logic [9:0]  req_row_index,
   input  wire logic [5:0]  req_column_index,
   input  wire logic signed [15:0] req_weight_value,
   input  wire logic [9:0]  req_token_id,
   input  wire logic        req_end_of_sequence,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_class_index,
   output logic [15:0]      rsp_probability,
   output logic [3:0]       rsp_best_class,
   output logic             rsp_last_result
);
   localparam int HW = $clog2(HIDDEN_SIZE) > 0 ? $clog2(HIDDEN_SIZE) : 1;
   localparam int EW = $clog2(EMBED_SIZE) > 0 ? $clog2(EMBED_SIZE) : 1;
   localparam int OW = $clog2(OUTPUT_SIZE);
   localparam int VW = $clog2(VOCAB_SIZE);
   localparam int EMB_D = VOCAB_SIZE * EMBED_SIZE;
   localparam int WX_D  = EMBED_SIZE * HIDDEN_SIZE;
   localparam int WH_D  = HIDDEN_SIZE * HIDDEN_SIZE;
   localparam int WY_D  = HIDDEN_SIZE * OUTPUT_SIZE;
   localparam int EMBW  = $clog2(EMB_D);
   localparam int WXW   = $clog2(WX_D) > 0 ? $clog2(WX_D) : 1;
   localparam int WHW   = $clog2(WH_D) > 0 ? $clog2(WH_D) : 1;
   localparam int WYW   = $clog2(WY_D);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HB    = 4'd1;
   localparam logic [3:0] S_XMAC  = 4'd2;
   localparam logic [3:0] S_HMAC  = 4'd3;
   localparam logic [3:0] S_HWR   = 4'd4;
   localparam logic [3:0] S_COPY  = 4'd5;
   localparam logic [3:0] S_OB    = 4'd6;
   localparam logic [3:0] S_OMAC  = 4'd7;
   localparam logic [3:0] S_OWR   = 4'd8;
   localparam logic [3:0] S_EXP   = 4'd9;
   localparam logic [3:0] S_DIV   = 4'd10;
   localparam logic [3:0] S_DWAIT = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;
   localparam logic [3:0] S_CLR   = 4'd13;
   localparam logic [3:0] S_BEST  = 4'd14;

   // stores
   rnnsc_pkg::q412_type emb_mem [EMB_D];
   rnnsc_pkg::q412_type wx_mem  [WX_D];
   rnnsc_pkg::q412_type wh_mem  [WH_D];
   rnnsc_pkg::q412_type bh_mem  [HIDDEN_SIZE];
   rnnsc_pkg::q412_type wy_mem  [WY_D];
   rnnsc_pkg::q412_type by_mem  [OUTPUT_SIZE];
   rnnsc_pkg::q412_type h_mem   [HIDDEN_SIZE];
   rnnsc_pkg::q412_type hn_mem  [HIDDEN_SIZE];

   rnnsc_pkg::q412_type emb_rd, wx_rd, wh_rd, bh_rd, wy_rd, by_rd, h_rd, hn_rd;

   logic [3:0]  st_ff, st_in;
   logic [HW:0] j_ff, j_in;     // outer index (hidden unit / class)
   logic [HW:0] k_ff, k_in;     // inner index
   logic        rd_ff, rd_in;   // read issued last cycle
   logic        eos_ff, eos_in;
   logic        tok_ok_ff, tok_ok_in;
   logic [VW-1:0] tok_ff, tok_in;
   logic        hzero_ff, hzero_in; // hidden vector reads as zero
   rnnsc_pkg::acc_type acc_ff, acc_in;
   logic signed [31:0] prod_ff, prod_in;
   logic        pv_ff, pv_in;
   logic signed [15:0] z_ff [OUTPUT_SIZE];
   logic [16:0] e_ff [OUTPUT_SIZE];
   logic [15:0] p_ff [OUTPUT_SIZE];
   logic [20:0] sum_ff, sum_in;
   logic signed [15:0] zmax_ff, zmax_in;
   logic [3:0]  best_ff, best_in;
   logic        ld_ff, ld_in;

   // memory control
   logic rd_en;
   logic [EMBW-1:0] emb_ra;
   logic [WXW-1:0]  wx_ra;
   logic [WHW-1:0]  wh_ra;
   logic [WYW-1:0]  wy_ra;
   logic [HW-1:0]   hrow_ra;
   logic            hn_we, h_we;
   logic [HW-1:0]   hw_a;
   rnnsc_pkg::q412_type hw_d;

   // divider
   logic        div_start, div_done;
   logic [40:0] div_num, div_quo;

   logic req_acc;
   assign req_ready = (st_ff == S_IDLE) && !ld_ff;
   assign req_acc   = req_valid && req_ready;

   // exp helper
   function automatic logic [16:0] exp_neg(input logic [16:0] d);
      logic [29:0] y;
      logic [4:0]  i;
      logic [7:0]  s;
      logic [16:0] a, b;
      logic [24:0] m;
      logic [16:0] v;
      logic [17:0] n;
      y = (30'(d) * 30'd5909 + 30'd2048) >> 12;
      n = y[29:12];
      i = {1'b0, y[11:8]};
      s = y[7:0];
      a = rnnsc_pkg::pow2_tab(i);
      b = rnnsc_pkg::pow2_tab(5'(i + 5'd1));
      m = 25'(a - b) * 25'(s) + 25'd128;
      v = a - 17'(m >> 8);
      return (n >= 18'd31) ? 17'd0 : 17'(v >> n[4:0]);
   endfunction

   // load write path
   always_ff @(posedge clock) begin
      if (req_acc && req_func == rnnsc_pkg::FUNC_LOAD) begin
         case (req_region)
            rnnsc_pkg::REG_EMBED:
               if (32'(req_row_index) < VOCAB_SIZE && 32'(req_column_index) < EMBED_SIZE)
                  emb_mem[EMBW'(32'(req_row_index) * EMBED_SIZE
                                + 32'(req_column_index))] <= req_weight_value;
            rnnsc_pkg::REG_WX:
               if (32'(req_row_index) < EMBED_SIZE && 32'(req_column_index) < HIDDEN_SIZE)
                  wx_mem[WXW'(32'(req_row_index) * HIDDEN_SIZE
                              + 32'(req_column_index))] <= req_weight_value;
            rnnsc_pkg::REG_WH:
               if (32'(req_row_index) < HIDDEN_SIZE && 32'(req_column_index) < HIDDEN_SIZE)
                  wh_mem[WHW'(32'(req_row_index) * HIDDEN_SIZE
                              + 32'(req_column_index))] <= req_weight_value;
            rnnsc_pkg::REG_BH:
               if (32'(req_column_index) < HIDDEN_SIZE)
                  bh_mem[HW'(req_column_index)] <= req_weight_value;
            rnnsc_pkg::REG_WY:
               if (32'(req_row_index) < HIDDEN_SIZE && 32'(req_column_index) < OUTPUT_SIZE)
                  wy_mem[WYW'(32'(req_row_index) * OUTPUT_SIZE
                              + 32'(req_column_index))] <= req_weight_value;
            rnnsc_pkg::REG_BY:
               if (32'(req_column_index) < OUTPUT_SIZE)
                  by_mem[OW'(req_column_index)] <= req_weight_value;
            default: ;
         endcase
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         emb_rd <= emb_mem[emb_ra];
         wx_rd  <= wx_mem[wx_ra];
         wh_rd  <= wh_mem[wh_ra];
         wy_rd  <= wy_mem[wy_ra];
         h_rd   <= h_mem[hrow_ra];
         hn_rd  <= hn_mem[hrow_ra];
         bh_rd  <= bh_mem[HW'(j_ff)];
         by_rd  <= by_mem[OW'(j_ff)];
      end
      if (hn_we) hn_mem[hw_a] <= hw_d;
      if (h_we)  h_mem[hw_a]  <= hw_d;
   end

   // read addresses
   always_comb begin
      emb_ra  = EMBW'(32'(tok_ff) * EMBED_SIZE + 32'(k_ff[EW-1:0]));
      wx_ra   = WXW'(32'(k_ff[EW-1:0]) * HIDDEN_SIZE + 32'(j_ff[HW-1:0]));
      wh_ra   = WHW'(32'(k_ff[HW-1:0]) * HIDDEN_SIZE + 32'(j_ff[HW-1:0]));
      wy_ra   = WYW'(32'(k_ff[HW-1:0]) * OUTPUT_SIZE + 32'(j_ff[OW-1:0]));
      hrow_ra = (st_ff == S_COPY) ? j_ff[HW-1:0] : k_ff[HW-1:0];
   end

   rnnsc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(sum_ff), .done(div_done), .quo(div_quo)
   );

   logic [40:0] qsat;
   always_comb begin
      st_in = st_ff; j_in = j_ff; k_in = k_ff; rd_in = 1'b0;
      eos_in = eos_ff; tok_ok_in = tok_ok_ff; tok_in = tok_ff; hzero_in = hzero_ff;
      acc_in = acc_ff; prod_in = prod_ff; pv_in = 1'b0; sum_in = sum_ff;
      zmax_in = zmax_ff; best_in = best_ff; ld_in = 1'b0;
      rd_en = 1'b1; hn_we = 1'b0; h_we = 1'b0; hw_a = j_ff[HW-1:0]; hw_d = '0;
      div_start = 1'b0;
      div_num = {9'd0, e_ff[OW'(j_ff)], 15'd0} + 41'(sum_ff >> 1);
      div_num = 41'({e_ff[OW'(j_ff)], 16'd0}) + 41'(sum_ff >> 1);
      qsat = div_quo;
      rsp_valid = 1'b0;

      // MAC accumulate of last cycle's product
      if (pv_ff) acc_in = acc_ff + rnnsc_pkg::acc_type'(prod_ff);

      case (st_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_func == rnnsc_pkg::FUNC_LOAD) begin
                  ld_in = 1'b1;
               end else begin
                  tok_in = VW'(req_token_id);
                  tok_ok_in = 32'(req_token_id) < VOCAB_SIZE;
                  eos_in = req_end_of_sequence;
                  j_in = '0; st_in = S_HB;
               end
            end
         end
         S_HB: begin  // bias read issued by rd_en, load accumulator next
            k_in = '0; rd_in = 1'b0;
            st_in = tok_ok_ff ? S_XMAC : S_HMAC;
            pv_in = 1'b0;
            acc_in = '0;
         end
         S_XMAC: begin
            if (k_ff == (HW+1)'(0) && !rd_ff) acc_in = rnnsc_pkg::acc_type'(bh_rd) <<< 12;
            if (rd_ff) begin
               prod_in = emb_rd * wx_rd; pv_in = 1'b1;
            end
            if (32'(k_ff) < EMBED_SIZE) begin
               k_in = k_ff + 1'b1; rd_in = 1'b1;
            end else begin
               k_in = '0; st_in = S_HMAC;
            end
         end
         S_HMAC: begin
            if (!tok_ok_ff && k_ff == (HW+1)'(0) && !rd_ff)
               acc_in = rnnsc_pkg::acc_type'(bh_rd) <<< 12;
            if (rd_ff && st_ff == S_HMAC && k_ff != (HW+1)'(0)) begin
               prod_in = (hzero_ff ? 16'sd0 : h_rd) * wh_rd; pv_in = 1'b1;
            end
            if (32'(k_ff) < HIDDEN_SIZE) begin
               k_in = k_ff + 1'b1; rd_in = 1'b1;
            end else if (!rd_ff && !pv_ff) begin
               st_in = S_HWR;
            end
            if (32'(k_ff) == HIDDEN_SIZE && rd_ff) begin
               prod_in = (hzero_ff ? 16'sd0 : h_rd) * wh_rd; pv_in = 1'b1;
            end
         end
         S_HWR: begin
            hn_we = 1'b1; hw_d = rnnsc_pkg::tanh_q(rnnsc_pkg::to_q412(acc_ff));
            if (32'(j_ff) == HIDDEN_SIZE - 1) begin
               j_in = '0; st_in = S_COPY;
            end else begin
               j_in = j_ff + 1'b1; st_in = S_HB;
            end
         end
         S_COPY: begin  // hn -> h, one entry a cycle, from registered hn reads
            if (rd_ff) begin
               h_we = 1'b1; hw_a = k_ff[HW-1:0]; hw_d = hn_rd;
            end
            k_in = j_ff;
            if (32'(j_ff) < HIDDEN_SIZE) begin
               j_in = j_ff + 1'b1; rd_in = 1'b1;
            end else if (!rd_ff) begin
               hzero_in = 1'b0; j_in = '0;
               st_in = eos_ff ? S_OB : S_IDLE;
            end
         end
         S_OB: begin
            k_in = '0; acc_in = '0; st_in = S_OMAC;
         end
         S_OMAC: begin
            if (k_ff == (HW+1)'(0) && !rd_ff) acc_in = rnnsc_pkg::acc_type'(by_rd) <<< 12;
            if (rd_ff) begin
               prod_in = h_rd * wy_rd; pv_in = 1'b1;
            end
            if (32'(k_ff) < HIDDEN_SIZE) begin
               k_in = k_ff + 1'b1; rd_in = 1'b1;
            end else if (!rd_ff && !pv_ff) begin
               st_in = S_OWR;
            end
         end
         S_OWR: begin
            if (j_ff == '0 || rnnsc_pkg::to_q412(acc_ff) > zmax_ff)
               zmax_in = rnnsc_pkg::to_q412(acc_ff);
            if (32'(j_ff) == OUTPUT_SIZE - 1) begin
               j_in = '0; sum_in = '0; st_in = S_EXP;
            end else begin
               j_in = j_ff + 1'b1; st_in = S_OB;
            end
         end
         S_EXP: begin
            sum_in = sum_ff + 21'(exp_neg(17'(18'(zmax_ff) - 18'(z_ff[OW'(j_ff)]))));
            if (32'(j_ff) == OUTPUT_SIZE - 1) begin
               j_in = '0; st_in = S_DIV;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_DIV: begin
            div_start = 1'b1; st_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               if (32'(j_ff) == OUTPUT_SIZE - 1) begin
                  j_in = '0; best_in = '0; st_in = S_BEST;
               end else begin
                  j_in = j_ff + 1'b1; st_in = S_DIV;
               end
            end
         end
         S_BEST: begin
            if (p_ff[OW'(j_ff)] > p_ff[OW'(best_ff)]) best_in = 4'(j_ff);
            if (32'(j_ff) == OUTPUT_SIZE - 1) begin
               j_in = '0; st_in = S_EMIT;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (32'(j_ff) == OUTPUT_SIZE - 1) begin
                  j_in = '0; st_in = S_CLR;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         S_CLR: begin
            hzero_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign rsp_class_index = 4'(j_ff);
   assign rsp_probability = p_ff[OW'(j_ff)];
   assign rsp_best_class  = best_ff;
   assign rsp_last_result = (32'(j_ff) == OUTPUT_SIZE - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; j_ff <= '0; k_ff <= '0; rd_ff <= 1'b0; pv_ff <= 1'b0;
         hzero_ff <= 1'b1; ld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; j_ff <= j_in; k_ff <= k_in; rd_ff <= rd_in; pv_ff <= pv_in;
         hzero_ff <= hzero_in; ld_ff <= ld_in;
      end
      eos_ff <= eos_in; tok_ok_ff <= tok_ok_in; tok_ff <= tok_in;
      acc_ff <= acc_in; prod_ff <= prod_in; sum_ff <= sum_in;
      zmax_ff <= zmax_in; best_ff <= best_in;
      if (st_ff == S_OWR) z_ff[OW'(j_ff)] <= rnnsc_pkg::to_q412(acc_ff);
      if (st_ff == S_EXP)
         e_ff[OW'(j_ff)] <= exp_neg(17'(18'(zmax_ff) - 18'(z_ff[OW'(j_ff)])));
      if (st_ff == S_DWAIT && div_done)
         p_ff[OW'(j_ff)] <= (qsat > 41'd65535) ? 16'hffff : qsat[15:0];
   end
endmodule
`default_nettype wire
